FILE: rtl/dsc_pkg.sv
// Shared types, constants and square-lookup functions for the digraph square cipher.
`default_nettype none

package dsc_pkg;

    localparam int SQ_DIM   = 5;
    localparam int SQ_CELLS = SQ_DIM * SQ_DIM;
    localparam int CHAR_W   = 8;
    localparam int ROW_W    = SQ_DIM * CHAR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;
    localparam int POS_W    = 3;
    localparam int CELL_W   = 5;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int CNT_W  = 3;
    localparam logic [CNT_W-1:0] Q_ACCEPT_MAX = CNT_W'(QDEPTH - 2);
    localparam logic [CNT_W-1:0] Q_FULL       = CNT_W'(QDEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd6;

    localparam logic [7:0] RST_MISSING = 8'h4A;
    localparam logic [7:0] RST_REPL    = 8'h49;
    localparam logic [7:0] RST_FILLER  = 8'h58;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;

    typedef struct packed {
        logic [SQ_CELLS-1:0][CHAR_W-1:0] sq;
        char_t missing;
        char_t repl;
        char_t filler;
        logic  mode;
    } cfg_t;

    typedef struct packed {
        char_t a;
        char_t b;
        logic  last;
    } pair_t;

    typedef struct packed {
        char_t first;
        char_t second;
        logic  not_in_key;
        logic  last;
    } result_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } loc_t;

    function automatic logic [CELL_W-1:0] cell_idx(logic [POS_W-1:0] row,
                                                   logic [POS_W-1:0] col);
        return CELL_W'({row, 2'b00}) + CELL_W'(row) + CELL_W'(col);
    endfunction

    // Scan from the last cell back so the first row-major match wins.
    function automatic loc_t locate(logic [SQ_CELLS-1:0][CHAR_W-1:0] sq, char_t ch);
        loc_t l;
        l = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--)
        begin
            for (int c = SQ_DIM - 1; c >= 0; c--)
            begin
                if (sq[CELL_W'(r * SQ_DIM + c)] == ch)
                begin
                    l.found = 1'b1;
                    l.row   = POS_W'(r);
                    l.col   = POS_W'(c);
                end
            end
        end
        return l;
    endfunction

    function automatic logic [POS_W-1:0] step5(logic [POS_W-1:0] v, logic mode);
        logic [POS_W-1:0] r;
        if (mode == MODE_DECODE)
            r = (v == '0) ? POS_W'(SQ_DIM - 1) : v - POS_W'(1);
        else
            r = (v == POS_W'(SQ_DIM - 1)) ? '0 : v + POS_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dsc_cfg.sv
// Configuration register bank: key square, substitution letters and mode.
`default_nettype none

module dsc_cfg (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [dsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [dsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dsc_pkg::cfg_t                     cfg
);
    import dsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (cfg_index)
                CFG_KEY_ROW0, CFG_KEY_ROW1, CFG_KEY_ROW2, CFG_KEY_ROW3, CFG_KEY_ROW4:
                begin
                    for (int j = 0; j < SQ_DIM; j++)
                        cfg_next.sq[cell_idx(cfg_index, POS_W'(j))] =
                            cfg_data[j*CHAR_W +: CHAR_W];
                end
                CFG_FILL:
                begin
                    cfg_next.missing = cfg_data[7:0];
                    cfg_next.repl    = cfg_data[15:8];
                    cfg_next.filler  = cfg_data[23:16];
                end
                CFG_MODE:
                    cfg_next.mode = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sq      <= '0;
            cfg_reg.missing <= RST_MISSING;
            cfg_reg.repl    <= RST_REPL;
            cfg_reg.filler  <= RST_FILLER;
            cfg_reg.mode    <= MODE_ENCODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dsc_pair.sv
// Pair former: letter substitution, held letter, padding and a small pair queue.
`default_nettype none

module dsc_pair (
    input  wire                  clk,
    input  wire                  rst_n,
    input  dsc_pkg::cfg_t        cfg,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire  [7:0]           in_char,
    input  wire                  in_last,
    output logic                 head_valid,
    output dsc_pkg::pair_t       head,
    input  wire                  pop
);
    import dsc_pkg::*;

    pair_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    char_t             held_char_reg, held_char_next;
    logic              held_valid_reg, held_valid_next;

    logic              acc;
    char_t             c;
    logic              push0, push1;
    pair_t             pair0, pair1;
    logic [CNT_W-1:0]  n_push;

    assign in_ready   = count_reg <= Q_ACCEPT_MAX;
    assign acc        = in_valid && in_ready;
    assign c          = (in_char == cfg.missing) ? cfg.repl : in_char;
    assign head_valid = count_reg != '0;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        push0           = 1'b0;
        push1           = 1'b0;
        pair0           = '{a: held_char_reg, b: c, last: in_last};
        pair1           = '{a: c, b: cfg.filler, last: 1'b1};
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        if (acc)
        begin
            if (!held_valid_reg)
            begin
                if (in_last)
                begin
                    push0 = 1'b1;
                    pair0 = '{a: c, b: cfg.filler, last: 1'b1};
                end
                else
                begin
                    held_char_next  = c;
                    held_valid_next = 1'b1;
                end
            end
            else if (held_char_reg == c)
            begin
                push0 = 1'b1;
                pair0 = '{a: held_char_reg, b: cfg.filler, last: 1'b0};
                if (in_last)
                begin
                    push1           = 1'b1;
                    held_char_next  = '0;
                    held_valid_next = 1'b0;
                end
            end
            else
            begin
                push0           = 1'b1;
                held_char_next  = '0;
                held_valid_next = 1'b0;
            end
        end
        n_push      = CNT_W'(push0) + CNT_W'(push1);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            q_reg[wr_ptr_reg] <= pair0;
        if (push1)
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= pair1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_FULL)
        else $error("pair queue count exceeds depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pair queue popped while empty");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && in_last) |=> !held_valid_reg)
        else $error("letter still held after final byte");

endmodule

`default_nettype wire

FILE: rtl/dsc_xform.sv
// Key square lookup and Playfair row, column and rectangle transform of one pair.
`default_nettype none

module dsc_xform (
    input  dsc_pkg::cfg_t     cfg,
    input  dsc_pkg::pair_t    pair,
    output dsc_pkg::result_t  res
);
    import dsc_pkg::*;

    loc_t l1, l2;
    logic both;

    assign l1   = locate(cfg.sq, pair.a);
    assign l2   = locate(cfg.sq, pair.b);
    assign both = l1.found && l2.found;

    always_comb
    begin
        res.first      = pair.a;
        res.second     = pair.b;
        res.not_in_key = !both;
        res.last       = pair.last;
        if (both)
        begin
            if (l1.row == l2.row)
            begin
                res.first  = cfg.sq[cell_idx(l1.row, step5(l1.col, cfg.mode))];
                res.second = cfg.sq[cell_idx(l2.row, step5(l2.col, cfg.mode))];
            end
            else if (l1.col == l2.col)
            begin
                res.first  = cfg.sq[cell_idx(step5(l1.row, cfg.mode), l1.col)];
                res.second = cfg.sq[cell_idx(step5(l2.row, cfg.mode), l2.col)];
            end
            else
            begin
                res.first  = cfg.sq[cell_idx(l1.row, l2.col)];
                res.second = cfg.sq[cell_idx(l2.row, l1.col)];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/digraph_square_cipher_unit.sv
// Top level of the digraph square cipher: configuration, pair former, transform, result register.
//
//  channel  | direction | signals                               | contents
//  ---------+-----------+---------------------------------------+---------------------------
//  s_axis   | in        | tvalid tready tdata[7:0] tlast        | message byte, final-byte mark
//  m_axis   | out       | tvalid tready tdata[15:0] tuser tlast | transformed pair, flag, final
//  cfg      | in        | valid ready index[2:0] data[39:0]     | register write
//
// One byte is accepted per cycle while s_axis_tready is high; a pair is written to the pair
// queue at the edge that accepts its second byte, then moves to the result register once that
// register is free. A repeated letter on the final byte pushes two pairs at once into the four-entry queue.
// s_axis_tready drops while the queue holds three or more pairs; a stalled m_axis
// holds the result register. Reset clears the held letter, the queue and the key.
`default_nettype none

module digraph_square_cipher_unit (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [7:0]                        s_axis_tdata,   // [7:0] in_char
    input  wire                               s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [7:0] out_first, [15:8] out_second
    output logic                              m_axis_tuser,   // [0] not_in_key
    output logic                              m_axis_tlast,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [dsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [dsc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dsc_pkg::*;

    cfg_t    cfg;
    logic    head_valid;
    pair_t   head;
    logic    pop;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    dsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsc_pair u_pair (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    dsc_xform u_xform (
        .cfg  (cfg),
        .pair (head),
        .res  (res)
    );

    assign pop            = head_valid && (!out_valid_reg || m_axis_tready);
    assign out_valid_next = pop || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.second, out_reg.first};
    assign m_axis_tuser  = out_reg.not_in_key;
    assign m_axis_tlast  = out_reg.last;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the digraph square cipher unit: byte stream in, cipher pairs out.
module testbench;
    import dsc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    class cipher_scoreboard;
        char_t     key_sq [5][5];
        char_t     missing;
        char_t     repl;
        char_t     filler;
        logic      cipher_mode;
        char_t     held;
        bit        held_ok;
        result_t   pending[$];
        int unsigned mismatches;

        function new();
            foreach (key_sq[r, c])
                key_sq[r][c] = '0;
            missing     = RST_MISSING;
            repl        = RST_REPL;
            filler      = RST_FILLER;
            cipher_mode = MODE_ENCODE;
            held        = '0;
            held_ok     = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx <= CFG_KEY_ROW4)
            begin
                for (int c = 0; c < 5; c++)
                    key_sq[idx][c] = data[8*c +: 8];
            end
            else if (idx == CFG_FILL)
            begin
                missing = data[7:0];
                repl    = data[15:8];
                filler  = data[23:16];
            end
            else if (idx == CFG_MODE)
                cipher_mode = data[0];
        endfunction

        function bit find(char_t ch, output int row, output int col);
            row = 0;
            col = 0;
            for (int r = 0; r < 5; r++)
            begin
                for (int c = 0; c < 5; c++)
                begin
                    if (key_sq[r][c] == ch)
                    begin
                        row = r;
                        col = c;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function result_t transform(char_t a, char_t b, logic last);
            result_t res;
            int      ra, ca, rb, cb, shift;
            bit      fa, fb;
            fa = find(a, ra, ca);
            fb = find(b, rb, cb);
            shift = (cipher_mode == MODE_DECODE) ? 4 : 1;
            res.first      = a;
            res.second     = b;
            res.not_in_key = !(fa && fb);
            res.last       = last;
            if (fa && fb)
            begin
                if (ra == rb)
                begin
                    res.first  = key_sq[ra][(ca + shift) % 5];
                    res.second = key_sq[rb][(cb + shift) % 5];
                end
                else if (ca == cb)
                begin
                    res.first  = key_sq[(ra + shift) % 5][ca];
                    res.second = key_sq[(rb + shift) % 5][cb];
                end
                else
                begin
                    res.first  = key_sq[ra][cb];
                    res.second = key_sq[rb][ca];
                end
            end
            return res;
        endfunction

        function void take_byte(char_t ch, logic last);
            char_t c;
            c = (ch == missing) ? repl : ch;
            if (!held_ok)
            begin
                if (last)
                    pending.push_back(transform(c, filler, 1'b1));
                else
                begin
                    held    = c;
                    held_ok = 1'b1;
                end
            end
            else if (held == c)
            begin
                pending.push_back(transform(held, filler, 1'b0));
                if (last)
                begin
                    pending.push_back(transform(c, filler, 1'b1));
                    held_ok = 1'b0;
                    held    = '0;
                end
            end
            else
            begin
                pending.push_back(transform(held, c, last));
                held_ok = 1'b0;
                held    = '0;
            end
        endfunction

        function void check_pair(char_t first, char_t second, logic flag, logic last);
            result_t want;
            if (pending.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected pair: first=%h second=%h flag=%b last=%b",
                             first, second, flag, last);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (want.first != first || want.second != second ||
                want.not_in_key != flag || want.last != last)
            begin
                if (mismatches < 10)
                    $display("pair mismatch: want %h %h flag=%b last=%b, got %h %h flag=%b last=%b",
                             want.first, want.second, want.not_in_key, want.last,
                             first, second, flag, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_valid   = 1'b0;
    char_t                 s_data    = '0;
    logic                  s_last    = 1'b0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_ready;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    cipher_scoreboard board = new();

    digraph_square_cipher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_ready)
            board.check_pair(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser, m_axis_tlast);
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #4000000;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic send_byte(input char_t ch, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= ch;
        s_last  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.take_byte(ch, last);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], i == txt.len() - 1);
    endtask

    task automatic wait_idle();
        int unsigned waited = 0;
        s_valid <= 1'b0;
        while (board.pending.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    task automatic write_config(input logic [4:0][39:0] rows, input logic [23:0] fill,
                                input logic mode_bit);
        for (int r = 0; r < 5; r++)
            write_reg(CFG_KEY_ROW0 + CFG_IDX_W'(r), rows[r]);
        write_reg(CFG_UNUSED, CFG_DATA_W'({$urandom(), $urandom()}));
        write_reg(CFG_FILL, {16'($urandom()), fill});
        write_reg(CFG_MODE, {39'({$urandom(), $urandom()}), mode_bit});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [39:0] pack_row(input string s);
        logic [39:0] v;
        for (int j = 0; j < 5; j++)
            v[8*j +: 8] = s[j];
        return v;
    endfunction

    function automatic char_t any_cell(input logic [4:0][39:0] rows);
        int r, c;
        r = $urandom_range(4);
        c = $urandom_range(4);
        return rows[r][8*c +: 8];
    endfunction

    function automatic char_t pick_letter(input char_t prev);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return prev;
        if (roll < 20)
            return board.missing;
        if (roll < 25)
            return board.filler;
        if (roll < 32)
            return char_t'($urandom_range(255));
        return board.key_sq[$urandom_range(4)][$urandom_range(4)];
    endfunction

    task automatic send_random_message(inout int sent);
        int    len;
        char_t ch;
        len = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 30);
        ch  = board.key_sq[0][0];
        for (int i = 0; i < len; i++)
        begin
            ch = pick_letter(ch);
            send_byte(ch, i == len - 1);
        end
        sent += len;
    endtask

    task automatic make_key(output logic [4:0][39:0] rows, input bit distinct);
        logic [255:0] used;
        char_t        pick;
        int           j;
        used = '0;
        for (int i = 0; i < 25; i++)
        begin
            pick = char_t'($urandom_range(255));
            if (distinct)
            begin
                while (used[pick])
                    pick = char_t'($urandom_range(255));
            end
            else if (i > 0 && $urandom_range(3) == 0)
            begin
                j    = $urandom_range(i - 1);
                pick = rows[j / 5][8*(j % 5) +: 8];
            end
            used[pick] = 1'b1;
            rows[i / 5][8*(i % 5) +: 8] = pick;
        end
    endtask

    initial
    begin
        logic [4:0][39:0] rows;
        logic [23:0]      fill;
        logic             mode_bit;
        int               sent;
        bit               paused;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1);
        wait_idle();
        rows[0] = pack_row("PLAYF");
        rows[1] = pack_row("IREXM");
        rows[2] = pack_row("BCDGH");
        rows[3] = pack_row("KNOQS");
        rows[4] = pack_row("TUVWZ");
        for (int r = 0; r < 5; r++)
            write_reg(CFG_KEY_ROW0 + CFG_IDX_W'(r), rows[r]);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_text("HIDE");
        send_text("JAYY");
        send_text("PLLZ");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_text("XX");
        send_text("Q");
        wait_idle();
        write_reg(CFG_MODE, {39'd0, MODE_DECODE});
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_text("HIDE");
        send_text("PL");
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            if (ph == 6)
            begin
                rows     = '1;
                fill     = '1;
                mode_bit = MODE_DECODE;
            end
            else if (ph == 7)
            begin
                rows     = '0;
                fill     = '0;
                mode_bit = MODE_ENCODE;
            end
            else
            begin
                make_key(rows, $urandom_range(4) != 0);
                fill[7:0]   = ($urandom_range(9) < 6) ? any_cell(rows) : char_t'($urandom());
                fill[15:8]  = ($urandom_range(9) < 8) ? any_cell(rows) : char_t'($urandom());
                fill[23:16] = ($urandom_range(9) < 7) ? any_cell(rows) : char_t'($urandom());
                mode_bit    = ph[0] ? MODE_DECODE : MODE_ENCODE;
            end
            write_config(rows, fill, mode_bit);

            sent   = 0;
            paused = 1'b0;
            while (sent < 250)
            begin
                send_random_message(sent);
                if (!paused && sent >= 125)
                begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        if (board.pending.size() != 0)
        begin
            $display("pairs never received: %0d", board.pending.size());
            board.mismatches += board.pending.size();
        end
        if (board.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

FILE: sim.f
rtl/dsc_pkg.sv
rtl/dsc_cfg.sv
rtl/dsc_pair.sv
rtl/dsc_xform.sv
rtl/digraph_square_cipher_unit.sv
tb/testbench.sv
